>>> rtl/core/q2e_pkg.sv
package q2e_pkg;

	typedef struct packed {
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
	} quat_in_t;

	typedef struct packed {
		logic signed [15:0] yaw_deg;
		logic signed [15:0] pitch_deg;
		logic signed [15:0] roll_deg;
	} euler_out_t;

	// Exact product sums: 28 fraction bits, magnitude below 2^33.
	localparam int PROD_W = 35;
	localparam int PROD_FRAC = 28;
	localparam int TAB_FRAC = 30;

	localparam logic [31:0] HALF_PI_Q30 = 32'h6487ED51;

	// atan(2^-i) scaled by 2^30, truncated but for entries 27 to 30, which are rounded.
	localparam logic [31:0] ATAN_Q30 [32] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
		32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
		32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
		32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
		32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008,
		32'h00000004, 32'h00000002, 32'h00000001, 32'h00000000
	};

	// Radians to 1/128 degree is near 36672 / 5; the /5 is a reciprocal multiply.
	localparam int DEG_NUM = 36672;
	localparam int DEG_DEN = 5;
	localparam int QUO_W = 18;
	localparam int RECIP_SH = 22;
	localparam logic [19:0] RECIP5 = 20'd838861;

endpackage

>>> rtl/core/quaternion_to_euler.sv
// Converts an attitude quaternion (signed, 16384 = 1.0) to Z-Y-X Euler angles in
// 1/128 degree: yaw and roll by atan2 of the product terms, pitch by asin of the
// sine term, clamped to [-1, 1] so that inputs whose sine term passes one give
// +-90 degrees. The block is a full pipeline and takes one transaction per clock
// while the output is not stalled. Its depth is set by the square root (one bit per
// stage) ahead of the pitch CORDIC and by the CORDIC stage count. The whole pipeline
// holds while a finished result is stalled.
module quaternion_to_euler #(
	parameter int FRAC_BITS = 14,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	output logic                   sample_stall,
	input  q2e_pkg::quat_in_t      sample,
	output logic                   angle_valid,
	input  logic                   angle_stall,
	output q2e_pkg::euler_out_t    angle
);
	localparam int F = FRAC_BITS;
	localparam int W = FRAC_BITS + 8;
	localparam int R = FRAC_BITS + 1;
	localparam int PW = 5 * W;
	localparam int LAT = 3 + R + 1 + CORDIC_STEPS + 3;

	logic en;
	logic [LAT-1:0] vld_q;

	logic signed [W-1:0] yn, yd, rn, rd, sn;
	logic [2*F:0] c2;
	logic [R-1:0] root;
	logic [PW-1:0] pass_out;
	logic signed [W-1:0] yn_d, yd_d, rn_d, rd_d, sn_d, cos_v;
	logic signed [W-1:0] yaw_ang, pitch_ang, roll_ang;
	logic signed [15:0] yaw_v, pitch_v, roll_v;

	assign en = !angle_valid || !angle_stall;
	assign sample_stall = !en;

	q2e_prod #(.F(F), .W(W)) u_prod (
		.clk(clk), .en(en), .sample(sample),
		.yn(yn), .yd(yd), .rn(rn), .rd(rd), .sn(sn), .c2(c2)
	);

	q2e_isqrt #(.F(F), .PW(PW)) u_isqrt (
		.clk(clk), .en(en), .radicand(c2),
		.pass_in({yn, yd, rn, rd, sn}),
		.root(root), .pass_out(pass_out)
	);

	assign {yn_d, yd_d, rn_d, rd_d, sn_d} = pass_out;
	assign cos_v = W'(root);

	q2e_cordic #(.F(F), .W(W), .STEPS(CORDIC_STEPS)) u_cordic_yaw (
		.clk(clk), .en(en), .y_in(yn_d), .x_in(yd_d), .angle(yaw_ang)
	);

	q2e_cordic #(.F(F), .W(W), .STEPS(CORDIC_STEPS)) u_cordic_pitch (
		.clk(clk), .en(en), .y_in(sn_d), .x_in(cos_v), .angle(pitch_ang)
	);

	q2e_cordic #(.F(F), .W(W), .STEPS(CORDIC_STEPS)) u_cordic_roll (
		.clk(clk), .en(en), .y_in(rn_d), .x_in(rd_d), .angle(roll_ang)
	);

	q2e_deg #(.F(F), .W(W)) u_deg_yaw (
		.clk(clk), .en(en), .angle(yaw_ang), .deg(yaw_v)
	);

	q2e_deg #(.F(F), .W(W)) u_deg_pitch (
		.clk(clk), .en(en), .angle(pitch_ang), .deg(pitch_v)
	);

	q2e_deg #(.F(F), .W(W)) u_deg_roll (
		.clk(clk), .en(en), .angle(roll_ang), .deg(roll_v)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			angle_valid <= 1'b0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], sample_valid};
			angle_valid <= vld_q[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle.yaw_deg <= yaw_v;
			angle.pitch_deg <= pitch_v;
			angle.roll_deg <= roll_v;
		end
	end
endmodule

>>> rtl/core/q2e_prod.sv
module q2e_prod #(
	parameter int F = 14,
	parameter int W = 22
) (
	input  logic                 clk,
	input  logic                 en,
	input  q2e_pkg::quat_in_t    sample,
	output logic signed [W-1:0]  yn,
	output logic signed [W-1:0]  yd,
	output logic signed [W-1:0]  rn,
	output logic signed [W-1:0]  rd,
	output logic signed [W-1:0]  sn,
	output logic [2*F:0]         c2
);
	localparam int PW = q2e_pkg::PROD_W;
	localparam int SH_L = (F >= q2e_pkg::PROD_FRAC) ? F - q2e_pkg::PROD_FRAC : 0;
	localparam int SH_R = (F >= q2e_pkg::PROD_FRAC) ? 0 : q2e_pkg::PROD_FRAC - F;
	localparam int RND = (1 << SH_R) >> 1;
	localparam int EW = PW + SH_L + 1;
	localparam logic signed [PW-1:0] ONE_P = PW'(1) <<< q2e_pkg::PROD_FRAC;
	localparam logic signed [W-1:0] ONE_W = W'(1) <<< F;
	localparam logic signed [2*F+3:0] ONE_SQ = (2*F+4)'(1) <<< (2*F);

	function automatic logic signed [W-1:0] to_work(input logic signed [PW-1:0] v);
		logic signed [EW-1:0] e;
		e = EW'(v) + EW'(RND);
		e = e >>> SH_R;
		e = e <<< SH_L;
		return e[W-1:0];
	endfunction

	logic signed [31:0] xy_s1, wz_s1, yy_s1, zz_s1, yz_s1, wx_s1, xx_s1, wy_s1, xz_s1;
	logic signed [W-1:0] yn_s2, yd_s2, rn_s2, rd_s2;
	logic signed [F+1:0] sq_s2;
	logic signed [W-1:0] yn_v, yd_v, rn_v, rd_v, s_v;
	logic signed [F+1:0] sq_v;
	logic signed [2*F+3:0] ss_v;

	always_ff @(posedge clk) begin
		if (en) begin
			xy_s1 <= sample.quat_x * sample.quat_y;
			wz_s1 <= sample.quat_w * sample.quat_z;
			yy_s1 <= sample.quat_y * sample.quat_y;
			zz_s1 <= sample.quat_z * sample.quat_z;
			yz_s1 <= sample.quat_y * sample.quat_z;
			wx_s1 <= sample.quat_w * sample.quat_x;
			xx_s1 <= sample.quat_x * sample.quat_x;
			wy_s1 <= sample.quat_w * sample.quat_y;
			xz_s1 <= sample.quat_x * sample.quat_z;
		end
	end

	always_comb begin
		yn_v = to_work((PW'(xy_s1) + PW'(wz_s1)) <<< 1);
		yd_v = to_work(ONE_P - ((PW'(yy_s1) + PW'(zz_s1)) <<< 1));
		rn_v = to_work((PW'(yz_s1) + PW'(wx_s1)) <<< 1);
		rd_v = to_work(ONE_P - ((PW'(xx_s1) + PW'(yy_s1)) <<< 1));
		s_v  = to_work((PW'(wy_s1) - PW'(xz_s1)) <<< 1);
		// A non-unit quaternion can push the sine past one; hold it to the unit range.
		if (s_v > ONE_W) begin
			sq_v = (F+2)'(ONE_W);
		end else if (s_v < -ONE_W) begin
			sq_v = (F+2)'(-ONE_W);
		end else begin
			sq_v = (F+2)'(s_v);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			yn_s2 <= yn_v;
			yd_s2 <= yd_v;
			rn_s2 <= rn_v;
			rd_s2 <= rd_v;
			sq_s2 <= sq_v;
		end
	end

	assign ss_v = (2*F+4)'(sq_s2) * (2*F+4)'(sq_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			yn <= yn_s2;
			yd <= yd_s2;
			rn <= rn_s2;
			rd <= rd_s2;
			sn <= W'(sq_s2);
			c2 <= (2*F+1)'(ONE_SQ - ss_v);
		end
	end
endmodule

>>> rtl/core/q2e_isqrt.sv
module q2e_isqrt #(
	parameter int F = 14,
	parameter int PW = 110
) (
	input  logic          clk,
	input  logic          en,
	input  logic [2*F:0]  radicand,
	input  logic [PW-1:0] pass_in,
	output logic [F:0]    root,
	output logic [PW-1:0] pass_out
);
	localparam int R = F + 1;
	localparam int NW = 2 * F + 1;
	localparam int TW = 2 * F + 4;

	logic [NW-1:0] rem_s  [1:R];
	logic [R-1:0]  root_s [1:R];
	logic [PW-1:0] pass_s [1:R];

	// One root bit per stage, most significant first; rem holds radicand - root^2.
	for (genvar k = 0; k < R; k++) begin : g_bit
		localparam int B = R - 1 - k;
		logic [NW-1:0] rem_i;
		logic [R-1:0]  root_i;
		logic [PW-1:0] pass_i;
		logic [TW-1:0] trial;
		if (k == 0) begin : g_first
			assign rem_i = radicand;
			assign root_i = '0;
			assign pass_i = pass_in;
		end else begin : g_next
			assign rem_i = rem_s[k];
			assign root_i = root_s[k];
			assign pass_i = pass_s[k];
		end
		assign trial = ((TW'(root_i) << 1) | (TW'(1) << B)) << B;
		always_ff @(posedge clk) begin
			if (en) begin
				if (TW'(rem_i) >= trial) begin
					rem_s[k+1] <= rem_i - NW'(trial);
					root_s[k+1] <= root_i | (R'(1) << B);
				end else begin
					rem_s[k+1] <= rem_i;
					root_s[k+1] <= root_i;
				end
				pass_s[k+1] <= pass_i;
			end
		end
	end

	assign root = root_s[R];
	assign pass_out = pass_s[R];
endmodule

>>> rtl/core/q2e_cordic.sv
module q2e_cordic #(
	parameter int F = 14,
	parameter int W = 22,
	parameter int STEPS = 16
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [W-1:0] y_in,
	input  logic signed [W-1:0] x_in,
	output logic signed [W-1:0] angle
);
	localparam logic signed [W-1:0] HP =
		W'(q2e_pkg::HALF_PI_Q30 >> (q2e_pkg::TAB_FRAC - F));

	logic signed [W-1:0] x_s [STEPS+1];
	logic signed [W-1:0] y_s [STEPS+1];
	logic signed [W-1:0] z_s [STEPS+1];
	logic                zf_s [STEPS+1];

	// A vector in the left half plane is first turned a quarter turn toward the right.
	always_ff @(posedge clk) begin
		if (en) begin
			zf_s[0] <= (x_in == '0) && (y_in == '0);
			if (x_in < 0) begin
				if (y_in >= 0) begin
					x_s[0] <= y_in;
					y_s[0] <= -x_in;
					z_s[0] <= HP;
				end else begin
					x_s[0] <= -y_in;
					y_s[0] <= x_in;
					z_s[0] <= -HP;
				end
			end else begin
				x_s[0] <= x_in;
				y_s[0] <= y_in;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam logic [31:0] AQ = q2e_pkg::ATAN_Q30[i];
		localparam logic signed [W-1:0] A = W'(AQ >> (q2e_pkg::TAB_FRAC - F));
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + A;
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - A;
				end
				zf_s[i+1] <= zf_s[i];
			end
		end
	end

	assign angle = zf_s[STEPS] ? '0 : z_s[STEPS];
endmodule

>>> rtl/core/q2e_deg.sv
module q2e_deg #(
	parameter int F = 14,
	parameter int W = 22
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [W-1:0] angle,
	output logic signed [15:0]  deg
);
	localparam int QW = q2e_pkg::QUO_W;
	localparam int MW = W + 16;
	localparam logic [MW-1:0] HALF_DEN = MW'(q2e_pkg::DEG_DEN) << (F - 1);

	logic          neg_s1, neg_s2, neg_s3;
	logic [MW-1:0] num_s1;
	logic [QW-1:0] quo_s2;
	logic [QW-1:0] res_s3;
	logic [W-1:0]  mag_v;
	logic [MW-1:0] rnd_v;
	logic [QW+19:0] prod_v;

	assign mag_v = angle[W-1] ? W'(-angle) : W'(angle);

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= angle[W-1];
			num_s1 <= MW'(mag_v) * MW'(q2e_pkg::DEG_NUM);
		end
	end

	// Rounding half away from zero works on the magnitude; the power-of-two part goes first.
	assign rnd_v = (num_s1 + HALF_DEN) >> F;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s2 <= neg_s1;
			quo_s2 <= rnd_v[QW-1:0];
		end
	end

	assign prod_v = (QW+20)'(quo_s2) * (QW+20)'(q2e_pkg::RECIP5);

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s3 <= neg_s2;
			res_s3 <= QW'(prod_v >> q2e_pkg::RECIP_SH);
		end
	end

	always_comb begin
		if (!neg_s3) begin
			deg = (res_s3 > QW'(32767)) ? 16'sd32767 : 16'(res_s3);
		end else begin
			deg = (res_s3 > QW'(32768)) ? -16'sd32768 : 16'(-res_s3);
		end
	end
endmodule

>>> rtl/core/q2e_check.sv
module q2e_check (
	input logic                clk,
	input logic                arst_n,
	input logic                sample_valid,
	input logic                sample_stall,
	input q2e_pkg::quat_in_t   sample,
	input logic                angle_valid,
	input logic                angle_stall,
	input q2e_pkg::euler_out_t angle
);
	// The input side only waits when a finished result is held up.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (angle_valid && angle_stall))
		else $error("input stalled without a held result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(angle_valid && angle_stall) |=> angle_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(angle_valid && angle_stall) |=> $stable(angle))
		else $error("result changed while stalled");

	// Pitch comes from asin of a clamped argument, so it stays close to a quarter turn at most.
	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		angle_valid |-> (angle.pitch_deg <= 16'sd11600 && angle.pitch_deg >= -16'sd11600))
		else $error("pitch beyond a quarter turn");

	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		angle_valid |-> (angle.yaw_deg <= 16'sd23200 && angle.yaw_deg >= -16'sd23200
			&& angle.roll_deg <= 16'sd23200 && angle.roll_deg >= -16'sd23200))
		else $error("yaw or roll beyond a half turn");
endmodule

bind quaternion_to_euler q2e_check u_q2e_check (.*);

>>> tb/sv/quaternion_to_euler_test.sv
module quaternion_to_euler_test;

	localparam int FRAC_BITS = 14;
	localparam int CORDIC_STEPS = 16;
	localparam int LATENCY = 3 + (FRAC_BITS + 1) + (CORDIC_STEPS + 1) + 3 + 1;
	localparam int N_RANDOM = 600;
	localparam longint CYCLE_LIMIT = 200000;
	localparam int N_DIRECTED = 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	q2e_pkg::quat_in_t sample = '0;
	logic angle_valid;
	logic angle_stall = 1'b0;
	q2e_pkg::euler_out_t angle;

	quaternion_to_euler #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) DUT (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
		.angle_valid(angle_valid), .angle_stall(angle_stall), .angle(angle)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	typedef struct {
		q2e_pkg::quat_in_t q;
		bit has_angle;
		q2e_pkg::euler_out_t want;
	} quat_row_t;

	q2e_pkg::euler_out_t pending_angles[$];
	int errors = 0;
	int sent = 0;
	int received = 0;
	int clamped_count = 0;
	longint cycles = 0;
	bit quiet = 1'b0;
	bit hold_long = 1'b0;

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint to_frac(longint v);
		if (FRAC_BITS >= q2e_pkg::PROD_FRAC)
			return v <<< (FRAC_BITS - q2e_pkg::PROD_FRAC);
		return floor_shift(v + (64'sd1 <<< (q2e_pkg::PROD_FRAC - FRAC_BITS - 1)),
			q2e_pkg::PROD_FRAC - FRAC_BITS);
	endfunction

	function automatic longint int_sqrt(longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic longint vector_angle(longint y, longint x);
		longint z, t, dx, dy, a, hp;
		z = 0;
		hp = longint'(q2e_pkg::HALF_PI_Q30) >>> (q2e_pkg::TAB_FRAC - FRAC_BITS);
		if (x == 0 && y == 0)
			return 0;
		// Rotate a left half-plane vector into the right half first.
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = hp;
			end else begin
				x = -y; y = t; z = -hp;
			end
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			a = (i < 32) ? (longint'(q2e_pkg::ATAN_Q30[i]) >>> (q2e_pkg::TAB_FRAC - FRAC_BITS))
				: 0;
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (y >= 0) begin
				x += dx; y -= dy; z += a;
			end else begin
				x -= dx; y += dy; z -= a;
			end
		end
		return z;
	endfunction

	function automatic logic signed [15:0] rad_to_deg128(longint ang);
		longint num, den, r;
		num = ang * q2e_pkg::DEG_NUM;
		den = longint'(q2e_pkg::DEG_DEN) <<< FRAC_BITS;
		if (num >= 0)
			r = (num + den / 2) / den;
		else
			r = -((-num + den / 2) / den);
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r[15:0];
	endfunction

	function automatic q2e_pkg::euler_out_t euler_of(q2e_pkg::quat_in_t q);
		longint w, x, y, z, one_p, one_w, yn, yd, rn, rd, s, c;
		q2e_pkg::euler_out_t e;
		w = q.quat_w; x = q.quat_x; y = q.quat_y; z = q.quat_z;
		one_p = 64'sd1 <<< q2e_pkg::PROD_FRAC;
		one_w = 64'sd1 <<< FRAC_BITS;
		yn = to_frac(2 * (x * y + w * z));
		yd = to_frac(one_p - 2 * (y * y + z * z));
		rn = to_frac(2 * (y * z + w * x));
		rd = to_frac(one_p - 2 * (x * x + y * y));
		s = to_frac(2 * (w * y - x * z));
		if (s > one_w) s = one_w;
		if (s < -one_w) s = -one_w;
		c = int_sqrt(longint'(one_w * one_w - s * s));
		e.yaw_deg = rad_to_deg128(vector_angle(yn, yd));
		e.pitch_deg = rad_to_deg128(vector_angle(s, c));
		e.roll_deg = rad_to_deg128(vector_angle(rn, rd));
		return e;
	endfunction

	function automatic q2e_pkg::quat_in_t mk_quat(int w, int x, int y, int z);
		q2e_pkg::quat_in_t q;
		q.quat_w = w[15:0]; q.quat_x = x[15:0]; q.quat_y = y[15:0]; q.quat_z = z[15:0];
		return q;
	endfunction

	function automatic quat_row_t row(q2e_pkg::quat_in_t q, bit known, int yaw, int pitch,
			int roll);
		quat_row_t r;
		r.q = q;
		r.has_angle = known;
		r.want.yaw_deg = yaw[15:0];
		r.want.pitch_deg = pitch[15:0];
		r.want.roll_deg = roll[15:0];
		return r;
	endfunction

	function automatic int near_unit();
		return $urandom_range(0, 1) ? $urandom_range(0, 16384) : -$urandom_range(0, 16384);
	endfunction

	// Roughly unit quaternions: a random direction scaled to 16384.
	function automatic q2e_pkg::quat_in_t unit_quat();
		real a, b, c, d, n;
		a = $itor(near_unit()); b = $itor(near_unit());
		c = $itor(near_unit()); d = $itor(near_unit());
		n = $sqrt(a * a + b * b + c * c + d * d);
		if (n < 1.0)
			return mk_quat(16384, 0, 0, 0);
		return mk_quat($rtoi(a * 16384.0 / n), $rtoi(b * 16384.0 / n),
			$rtoi(c * 16384.0 / n), $rtoi(d * 16384.0 / n));
	endfunction

	task automatic send(q2e_pkg::quat_in_t q);
		sample_valid <= 1'b1;
		sample <= q;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		sent++;
	endtask

	task automatic sender_pause();
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 13);
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	quat_row_t directed[N_DIRECTED];

	initial begin
		q2e_pkg::quat_in_t q;
		int pct;
		// Zero and identity inputs still leave a small CORDIC residue on every angle,
		// so they are checked against the predictor.
		directed[0] = row(mk_quat(0, 0, 0, 0), 1'b0, 0, 0, 0);
		directed[1] = row(mk_quat(16384, 0, 0, 0), 1'b0, 0, 0, 0);
		directed[2] = row(mk_quat(-16384, 0, 0, 0), 1'b0, 0, 0, 0);
		// 180 degrees about z: yaw numerator 0, negative denominator.
		directed[3] = row(mk_quat(0, 0, 0, 16384), 1'b0, 0, 0, 0);
		directed[4] = row(mk_quat(0, 16384, 0, 0), 1'b0, 0, 0, 0);
		directed[5] = row(mk_quat(11585, 0, 11585, 0), 1'b0, 0, 0, 0);
		directed[6] = row(mk_quat(11585, 0, -11585, 0), 1'b0, 0, 0, 0);
		// Non-unit inputs; directed[7] and directed[8] push the sine term past one and clamp pitch.
		directed[7] = row(mk_quat(32767, 0, 32767, 0), 1'b0, 0, 0, 0);
		directed[8] = row(mk_quat(32767, 0, -32768, 0), 1'b0, 0, 0, 0);
		directed[9] = row(mk_quat(32767, 32767, 32767, 32767), 1'b0, 0, 0, 0);
		directed[10] = row(mk_quat(-32768, -32768, -32768, -32768), 1'b0, 0, 0, 0);
		directed[11] = row(mk_quat(-32768, 32767, -32768, 32767), 1'b0, 0, 0, 0);
		directed[12] = row(mk_quat(0, 0, 0, -16384), 1'b0, 0, 0, 0);
		directed[13] = row(mk_quat(11585, 11585, 0, 0), 1'b0, 0, 0, 0);
		directed[14] = row(mk_quat(1, -1, 1, -1), 1'b0, 0, 0, 0);
		directed[15] = row(mk_quat(-1, 1, -1, 1), 1'b0, 0, 0, 0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			pending_angles.push_back(directed[i].has_angle ? directed[i].want
				: euler_of(directed[i].q));
			send(directed[i].q);
			sender_pause();
		end

		// Long receiver hold while items keep coming, to fill the pipeline.
		hold_long = 1'b1;
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM - 100)
				quiet = 1'b1;
			pct = $urandom_range(0, 99);
			if (pct < 65)
				q = unit_quat();
			else if (pct < 90)
				q = mk_quat($urandom, $urandom, $urandom, $urandom);
			else
				q = mk_quat(near_unit() * 2, near_unit() * 2, near_unit(), near_unit());
			if (2 * (longint'(q.quat_w) * q.quat_y - longint'(q.quat_x) * q.quat_z)
					>= (64'sd1 <<< q2e_pkg::PROD_FRAC) ||
				2 * (longint'(q.quat_w) * q.quat_y - longint'(q.quat_x) * q.quat_z)
					<= -(64'sd1 <<< q2e_pkg::PROD_FRAC))
				clamped_count++;
			pending_angles.push_back(euler_of(q));
			send(q);
			sender_pause();
		end
		sample_valid <= 1'b0;

		while (pending_angles.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		$display("Sent %0d quaternions (%0d directed), checked %0d angle sets.",
			sent, N_DIRECTED, received);
		$display("%0d inputs saturated the pitch sine; idle and long-stall phases exercised.",
			clamped_count);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int n;
		wait (arst_n);
		forever begin
			if (hold_long) begin
				hold_long = 1'b0;
				angle_stall <= 1'b1;
				repeat (LATENCY * 3) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 13);
				angle_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end else begin
				angle_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		q2e_pkg::euler_out_t e;
		if (arst_n && angle_valid && !angle_stall) begin
			received++;
			if (pending_angles.size() == 0) begin
				$error("angle transaction with nothing expected: %h", angle);
				errors++;
			end else begin
				e = pending_angles.pop_front();
				if (angle.yaw_deg !== e.yaw_deg) begin
					$error("yaw_deg expected %0d actual %0d", e.yaw_deg, angle.yaw_deg);
					errors++;
				end
				if (angle.pitch_deg !== e.pitch_deg) begin
					$error("pitch_deg expected %0d actual %0d", e.pitch_deg, angle.pitch_deg);
					errors++;
				end
				if (angle.roll_deg !== e.roll_deg) begin
					$error("roll_deg expected %0d actual %0d", e.roll_deg, angle.roll_deg);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timed out with %0d angle sets outstanding.", pending_angles.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

endmodule
